// File: rtl/srr_pkg.sv
// Shared types, codes and default sizes for the selective repeat receiver.
package srr_pkg;

  // Fixed field widths of the packet and result words
  localparam int SEQ_W  = 16;
  localparam int DATA_W = 64;
  localparam int KIND_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int WIN_CFG_W  = 6;
  localparam int TOT_CFG_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CHUNKS = 1'd1;

  localparam logic [WIN_CFG_W-1:0] WIN_CFG_RESET = 6'd1;
  localparam logic [TOT_CFG_W-1:0] TOT_CFG_RESET = 9'd256;

  // Default sizes handed to the top level
  localparam int DEF_SEQ_COUNT    = 256;
  localparam int DEF_MAX_WINDOW   = 32;
  localparam int DEF_PAYLOAD_BITS = 64;

  // Result word kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

endpackage

// File: rtl/srr_if.sv
// Valid/ready channel interfaces for packet words and result words.
interface srr_pkt_if;
  logic                        valid;
  logic                        ready;
  logic [srr_pkg::SEQ_W-1:0]   seq_num;
  logic [srr_pkg::DATA_W-1:0]  payload;

  modport source (output valid, output seq_num, output payload, input ready);
  modport sink   (input valid, input seq_num, input payload, output ready);
endinterface

interface srr_res_if;
  logic                        valid;
  logic                        ready;
  srr_pkg::kind_e              kind;
  logic [srr_pkg::SEQ_W-1:0]   ack_num;
  logic [srr_pkg::DATA_W-1:0]  data_out;
  logic                        last;
  logic                        done_res;

  modport source (output valid, output kind, output ack_num, output data_out,
                  output last, output done_res, input ready);
  modport sink   (input valid, input kind, input ack_num, input data_out,
                  input last, input done_res, output ready);
endinterface

// File: rtl/srr_ram.sv
// Generic single write port RAM with registered read.
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/srr_alu.sv
// Shared add/subtract unit used by the receiver sequencer for its window and total checks.
module srr_alu #(
  parameter int W = 18
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o
);

  logic [W-1:0] b_eff;

  // Subtract as add of the inverted operand plus one
  assign b_eff = sub_i ? ~b_i : b_i;
  assign res_o = a_i + b_eff + W'(sub_i);

endmodule

// File: rtl/selective_repeat_receiver_core.sv
// Selective repeat ARQ receiver core: window check, slot store, in-order delivery.
// Flow: a packet is taken in idle; a done check sends it straight to the reply state, else
// total check, offset and class follow; an in-window packet then runs slot, wrap and write
// to its acknowledge word and delivers any chunks in order, other packets go to the reply.
// One packet is in work at a time; result stalls hold the sequencer, which shares one adder.
// Reset: window base 0, all received marks cleared at once, window width 1, total 256.
module selective_repeat_receiver_core #(
  parameter int SEQ_COUNT    = srr_pkg::DEF_SEQ_COUNT,
  parameter int MAX_WINDOW   = srr_pkg::DEF_MAX_WINDOW,
  parameter int PAYLOAD_BITS = srr_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  srr_pkt_if.sink                         pkt_i,
  srr_res_if.source                       res_o
);

  // Widths: base counts up to SEQ_COUNT, the ALU carries a sign bit beyond
  // the wider of base and sequence number plus one spare bit for sums.
  localparam int BASE_W = $clog2(SEQ_COUNT + 1);
  localparam int ALU_W  = ((BASE_W > srr_pkg::SEQ_W) ? BASE_W : srr_pkg::SEQ_W) + 2;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [ALU_W-1:0]  MAXW_A   = ALU_W'(MAX_WINDOW);
  localparam logic [ALU_W-1:0]  SEQC_A   = ALU_W'(SEQ_COUNT);
  localparam logic [ALU_W-1:0]  ONE_A    = ALU_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(MAX_WINDOW - 1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CHKDONE = 4'd1;
  localparam logic [3:0] ST_CHKTOT  = 4'd2;
  localparam logic [3:0] ST_OFF     = 4'd3;
  localparam logic [3:0] ST_CLASS   = 4'd4;
  localparam logic [3:0] ST_SLOT    = 4'd5;
  localparam logic [3:0] ST_WRAP    = 4'd6;
  localparam logic [3:0] ST_WRITE   = 4'd7;
  localparam logic [3:0] ST_ACK     = 4'd8;
  localparam logic [3:0] ST_REPLY   = 4'd9;
  localparam logic [3:0] ST_DCHK    = 4'd10;
  localparam logic [3:0] ST_DEMIT   = 4'd11;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [srr_pkg::WIN_CFG_W-1:0] win_cfg_q;
  logic [srr_pkg::TOT_CFG_W-1:0] tot_cfg_q;

  // Window state
  logic [BASE_W-1:0]     base_q;
  logic [SLOT_W-1:0]     base_slot_q;
  logic [MAX_WINDOW-1:0] marks_q;

  // Per-packet working registers
  logic [srr_pkg::SEQ_W-1:0] seq_q;
  logic [PAYLOAD_BITS-1:0]   data_q;
  logic [ALU_W-1:0]          off_q;
  logic [ALU_W-1:0]          tmp_q;
  logic [SLOT_W-1:0]         slot_q;
  logic                      seq_lt_tot_q;
  logic                      more_q;
  srr_pkg::kind_e            reply_kind_q;

  // Output register
  logic                       res_valid_q;
  srr_pkg::kind_e             res_kind_q;
  logic [srr_pkg::SEQ_W-1:0]  res_ack_q;
  logic [srr_pkg::DATA_W-1:0] res_data_q;
  logic                       res_last_q;
  logic                       res_done_q;

  // Shared unit
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub;
  logic             alu_neg;

  logic [ALU_W-1:0]        win_ext, tot_ext, eff_w, eff_tot, base_ext, seq_ext;
  logic [SLOT_W-1:0]       next_slot;
  logic                    next_mark;
  logic                    out_free;
  logic                    emit;
  logic                    accept;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  // Clamp the configured window to [1, MAX_WINDOW] and total to [1, SEQ_COUNT]
  assign win_ext = ALU_W'(win_cfg_q);
  assign tot_ext = ALU_W'(tot_cfg_q);
  assign eff_w   = (win_ext == '0) ? ONE_A : ((win_ext > MAXW_A) ? MAXW_A : win_ext);
  assign eff_tot = (tot_ext == '0) ? ONE_A : ((tot_ext > SEQC_A) ? SEQC_A : tot_ext);

  assign base_ext = ALU_W'(base_q);
  assign seq_ext  = ALU_W'(seq_q);

  // Slot of the chunk after base; with a single slot it is the one being freed
  assign next_slot = (base_slot_q == SLOT_TOP) ? '0 : base_slot_q + SLOT_W'(1);
  assign next_mark = (next_slot == base_slot_q) ? 1'b0 : marks_q[next_slot];

  assign accept   = pkt_i.valid && pkt_i.ready;
  assign out_free = !res_valid_q || res_o.ready;
  assign emit     = out_free && (state_q inside {ST_ACK, ST_REPLY, ST_DEMIT});

  assign pkt_i.ready = (state_q == ST_IDLE);

  // Operand select for the shared unit, one operation per state
  always_comb begin
    alu_a   = base_ext;
    alu_b   = eff_tot;
    alu_sub = 1'b1;
    case (state_q)
      ST_CHKDONE, ST_DCHK: begin
        alu_a   = base_ext;
        alu_b   = eff_tot;
        alu_sub = 1'b1;
      end
      ST_CHKTOT: begin
        alu_a   = seq_ext;
        alu_b   = eff_tot;
        alu_sub = 1'b1;
      end
      ST_OFF: begin
        alu_a   = seq_ext;
        alu_b   = base_ext;
        alu_sub = 1'b1;
      end
      ST_CLASS: begin
        // Ahead of base: offset - W; behind base: offset + W
        alu_a   = off_q;
        alu_b   = eff_w;
        alu_sub = !off_q[ALU_W-1];
      end
      ST_SLOT: begin
        alu_a   = ALU_W'(base_slot_q);
        alu_b   = off_q;
        alu_sub = 1'b0;
      end
      ST_WRAP: begin
        alu_a   = tmp_q;
        alu_b   = MAXW_A;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = base_ext;
        alu_b   = eff_tot;
        alu_sub = 1'b1;
      end
    endcase
  end

  srr_alu #(
    .W (ALU_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  assign alu_neg = alu_res[ALU_W-1];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pkt_i.valid) state_d = ST_CHKDONE;
      end
      ST_CHKDONE: begin
        // base below total: keep checking, else reply transfer done
        state_d = alu_neg ? ST_CHKTOT : ST_REPLY;
      end
      ST_CHKTOT: state_d = ST_OFF;
      ST_OFF:    state_d = ST_CLASS;
      ST_CLASS: begin
        if (!off_q[ALU_W-1] && alu_neg && seq_lt_tot_q) begin
          state_d = ST_SLOT;
        end else begin
          state_d = ST_REPLY;
        end
      end
      ST_SLOT:  state_d = ST_WRAP;
      ST_WRAP:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_ACK;
      ST_ACK: begin
        if (out_free) state_d = marks_q[base_slot_q] ? ST_DCHK : ST_IDLE;
      end
      ST_REPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_DCHK: state_d = ST_DEMIT;
      ST_DEMIT: begin
        if (out_free) state_d = (more_q && next_mark) ? ST_DCHK : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_cfg_q   <= srr_pkg::WIN_CFG_RESET;
      tot_cfg_q   <= srr_pkg::TOT_CFG_RESET;
      base_q      <= '0;
      base_slot_q <= '0;
      marks_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          srr_pkg::CFG_WIN_WIDTH:    win_cfg_q <= cfg_data_i[srr_pkg::WIN_CFG_W-1:0];
          srr_pkg::CFG_TOTAL_CHUNKS: tot_cfg_q <= cfg_data_i[srr_pkg::TOT_CFG_W-1:0];
          default: ;
        endcase
      end

      // Mark the slot as the payload goes into the store
      if (state_q == ST_WRITE) begin
        marks_q[slot_q] <= 1'b1;
      end

      // Free the slot and advance base as each chunk leaves
      if ((state_q == ST_DEMIT) && out_free) begin
        marks_q[base_slot_q] <= 1'b0;
        base_q               <= base_q + BASE_W'(1);
        base_slot_q          <= next_slot;
      end

      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q  <= pkt_i.seq_num;
      data_q <= pkt_i.payload[PAYLOAD_BITS-1:0];
    end
    case (state_q)
      ST_CHKDONE: reply_kind_q <= srr_pkg::KIND_DONE;
      ST_CHKTOT:  seq_lt_tot_q <= alu_neg;
      ST_OFF:     off_q        <= alu_res;
      ST_CLASS: begin
        // Behind base and within one window: re-acknowledge only
        reply_kind_q <= (off_q[ALU_W-1] && !alu_neg) ? srr_pkg::KIND_ACK
                                                     : srr_pkg::KIND_RANGE;
      end
      ST_SLOT: tmp_q <= alu_res;
      ST_WRAP: slot_q <= alu_neg ? tmp_q[SLOT_W-1:0] : alu_res[SLOT_W-1:0];
      // base - total is negative here; another chunk may follow unless it is -1
      ST_DCHK: more_q <= (alu_res != '1);
      default: ;
    endcase

    if (emit) begin
      case (state_q)
        ST_ACK: begin
          res_kind_q <= srr_pkg::KIND_ACK;
          res_ack_q  <= seq_q;
          res_data_q <= '0;
          res_last_q <= !marks_q[base_slot_q];
          res_done_q <= 1'b0;
        end
        ST_DEMIT: begin
          res_kind_q <= srr_pkg::KIND_DATA;
          res_ack_q  <= base_ext[srr_pkg::SEQ_W-1:0];
          res_data_q <= srr_pkg::DATA_W'(ram_rdata);
          res_last_q <= !(more_q && next_mark);
          res_done_q <= !more_q;
        end
        default: begin
          res_kind_q <= reply_kind_q;
          res_ack_q  <= seq_q;
          res_data_q <= '0;
          res_last_q <= 1'b1;
          res_done_q <= (reply_kind_q == srr_pkg::KIND_DONE);
        end
      endcase
    end
  end

  // Payload store: written at the packet's slot, read at base during delivery
  srr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WRITE),
    .waddr_i (slot_q),
    .wdata_i (data_q),
    .re_i    (state_q == ST_DCHK),
    .raddr_i (base_slot_q),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid    = res_valid_q;
  assign res_o.kind     = res_kind_q;
  assign res_o.ack_num  = res_ack_q;
  assign res_o.data_out = res_data_q;
  assign res_o.last     = res_last_q;
  assign res_o.done_res = res_done_q;

  // A delivery that finishes the transfer ends the packet's results
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == srr_pkg::KIND_DATA) && res_o.done_res) |-> res_o.last)
    else $error("final delivery not flagged last");

  // Only one packet in work at a time
  a_one_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !pkt_i.ready)
    else $error("packet taken while another is in work");

  // Delivery runs only from a marked base slot
  a_deliver_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DCHK) || (state_q == ST_DEMIT)) |-> marks_q[base_slot_q])
    else $error("delivery from an unmarked slot");

  // Base moves only when a chunk leaves
  a_base_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (base_q != $past(base_q)) |-> $past((state_q == ST_DEMIT) && out_free))
    else $error("window base moved without a delivery");

endmodule

// File: dv/selective_repeat_receiver_core_test.sv
// Self-checking testbench for the selective repeat ARQ receiver core.
`timescale 1ns / 100ps

module selective_repeat_receiver_core_test;

  localparam int SEQ_W      = srr_pkg::SEQ_W;
  localparam int DATA_W     = srr_pkg::DATA_W;
  localparam int WIN_CFG_W  = srr_pkg::WIN_CFG_W;
  localparam int TOT_CFG_W  = srr_pkg::TOT_CFG_W;
  localparam int CFG_IDX_W  = srr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = srr_pkg::CFG_DATA_W;

  localparam int SEQ_LIMIT    = srr_pkg::DEF_SEQ_COUNT;
  localparam int MAX_WIN      = srr_pkg::DEF_MAX_WINDOW;
  localparam int TOTAL_ITEMS  = 410;     // packets sent over the whole run
  localparam int SETTLE       = 32;      // cycles to let the sequencer go idle
  localparam int HOLD_OFF     = 400;     // one long receiver stall
  localparam int HOLD_AFTER   = 150;     // words seen before that stall
  localparam int RUN_LIMIT    = 600000;

  // One result word as the block should return it
  typedef struct {
    srr_pkg::kind_e    kind;
    logic [SEQ_W-1:0]  ack_num;
    logic [DATA_W-1:0] data_out;
    logic              last;
    logic              done_res;
  } res_t;

  // Directed rows: a packet, or a write of both registers
  typedef enum bit {ROW_PKT, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e              op;
    logic [SEQ_W-1:0]     seq;
    logic [DATA_W-1:0]    pl;
    bit                   typed;     // expected word typed in, ack_num = seq, data 0
    srr_pkg::kind_e       kind;
    logic                 last;
    logic                 done_res;
    logic [WIN_CFG_W-1:0] win;
    logic [TOT_CFG_W-1:0] tot;
  } row_t;

  // Kinds of stray packets mixed into the well-formed runs
  typedef enum logic [1:0] {NOISE_DUP, NOISE_OLD, NOISE_WILD, NOISE_EDGE} noise_e;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  srr_pkt_if pkt ();
  srr_res_if res ();

  selective_repeat_receiver_core #(
    .SEQ_COUNT   (srr_pkg::DEF_SEQ_COUNT),
    .MAX_WINDOW  (srr_pkg::DEF_MAX_WINDOW),
    .PAYLOAD_BITS(srr_pkg::DEF_PAYLOAD_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pkt_i     (pkt),
    .res_o     (res)
  );

  // Shadow copy of the receiver: registers, window base, marks and slot store
  logic [WIN_CFG_W-1:0] win_reg;
  logic [TOT_CFG_W-1:0] tot_reg;
  logic [8:0]           win_base;
  bit   [MAX_WIN-1:0]   got_mark;
  logic [DATA_W-1:0]    slot_data [MAX_WIN];

  res_t expected_words [$];
  int   mismatches;
  int   words_seen;
  int   packets_sent;
  int   cycle_count;
  bit   calm;              // both sides run without gaps while set

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop: a hung handshake or a lost word ends up here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Out-of-range window and total settings clamp to the legal span
  function automatic int unsigned eff_window();
    if (win_reg == 0) return 1;
    return (win_reg > MAX_WIN) ? MAX_WIN : win_reg;
  endfunction

  function automatic int unsigned eff_total();
    if (tot_reg == 0) return 1;
    return (tot_reg > SEQ_LIMIT) ? SEQ_LIMIT : tot_reg;
  endfunction

  // Work out the words one accepted packet causes and queue them in order.
  // The newest word is held back so that its last flag can still be set.
  task automatic predict_packet(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] pl,
                                output int produced);
    int unsigned w, tot, s, b;
    res_t held;
    w = eff_window();
    tot = eff_total();
    s = seq;
    b = win_base;
    produced = 0;
    held = '{srr_pkg::KIND_RANGE, seq, DATA_W'(0), 1'b1, 1'b0};
    if (b >= tot) begin
      // transfer finished: answer everything, change nothing
      held = '{srr_pkg::KIND_DONE, seq, DATA_W'(0), 1'b1, 1'b1};
    end else if (s >= b && s < b + w && s < tot) begin
      // in window: mark, store, then drain every consecutive marked slot from base
      got_mark[s % MAX_WIN] = 1'b1;
      slot_data[s % MAX_WIN] = pl;
      held = '{srr_pkg::KIND_ACK, seq, DATA_W'(0), 1'b0, 1'b0};
      while (b < tot && got_mark[b % MAX_WIN]) begin
        expected_words.push_back(held);
        produced++;
        got_mark[b % MAX_WIN] = 1'b0;
        held = '{srr_pkg::KIND_DATA, SEQ_W'(b), slot_data[b % MAX_WIN], 1'b0,
                 (b + 1 >= tot)};
        b++;
      end
      held.last = 1'b1;
      win_base = b[8:0];
    end else if (s < b && s + w >= b) begin
      // previous window: the sender lost our ack, so acknowledge again
      held = '{srr_pkg::KIND_ACK, seq, DATA_W'(0), 1'b1, 1'b0};
    end
    expected_words.push_back(held);
    produced++;
  endtask

  // Offer one packet word after a random gap and hold it until taken.
  // Valid stays high across back-to-back words, so it is lowered only ahead of a gap.
  task automatic offer_packet(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] pl);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      pkt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pkt.valid   <= 1'b1;
    pkt.seq_num <= seq;
    pkt.payload <= pl;
    do @(posedge clk_i); while (!pkt.ready);
    packets_sent++;
  endtask

  // Drop valid, wait until every expected word is back, then let the block settle
  task automatic drain();
    pkt.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the window width, then the total, with the write enable held across both
  task automatic write_cfg(input logic [WIN_CFG_W-1:0] win, input logic [TOT_CFG_W-1:0] tot);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= srr_pkg::CFG_WIN_WIDTH;
    cfg_data_i <= CFG_DATA_W'(win);
    @(posedge clk_i);
    cfg_idx_i  <= srr_pkg::CFG_TOTAL_CHUNKS;
    cfg_data_i <= CFG_DATA_W'(tot);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg = win;
    tot_reg = tot;
  endtask

  // Result side: random stalls per word, one long hold-off, compare in order
  initial begin : result_side
    int unsigned stall;
    bit held_off;
    res_t want;
    res.ready = 1'b0;
    held_off = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (!held_off && words_seen >= HOLD_AFTER) begin
        // hold off long enough for the block to fill and stall its input
        stall = HOLD_OFF;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      words_seen++;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d ack %0d", res.kind, res.ack_num));
      end else begin
        want = expected_words.pop_front();
        if (res.kind !== want.kind)
          flag_mismatch($sformatf("ack %0d: kind %0d, want %0d",
                                  want.ack_num, res.kind, want.kind));
        if (res.ack_num !== want.ack_num)
          flag_mismatch($sformatf("ack_num %0d, want %0d", res.ack_num, want.ack_num));
        if (res.data_out !== want.data_out)
          flag_mismatch($sformatf("ack %0d: data_out %h, want %h",
                                  want.ack_num, res.data_out, want.data_out));
        if (res.last !== want.last)
          flag_mismatch($sformatf("ack %0d: last %b, want %b",
                                  want.ack_num, res.last, want.last));
        if (res.done_res !== want.done_res)
          flag_mismatch($sformatf("ack %0d: done_res %b, want %b",
                                  want.ack_num, res.done_res, want.done_res));
      end
    end
  end

  // Packet side: reset, directed table, then random phases of window runs
  initial begin : packet_side
    row_t plan [$];
    int produced;
    int unsigned w, k, j, tmp, rnd;
    int unsigned burst_seqs [$];
    int nseq;
    logic [WIN_CFG_W-1:0] next_win;
    logic [TOT_CFG_W-1:0] next_tot;
    rst_ni      <= 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = srr_pkg::CFG_WIN_WIDTH;
    cfg_data_i  = '0;
    pkt.valid   = 1'b0;
    pkt.seq_num = '0;
    pkt.payload = '0;
    win_reg  = srr_pkg::WIN_CFG_RESET;
    tot_reg  = srr_pkg::TOT_CFG_RESET;
    win_base = '0;
    got_mark = '0;
    calm     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: window 1, total 256, base 0
    plan.push_back('{ROW_PKT, 16'd5, 64'd0, 1'b1, srr_pkg::KIND_RANGE, 1'b1, 1'b0,
                     6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd0, '1, 1'b0, srr_pkg::KIND_ACK, 1'b0, 1'b0, 6'd0, 9'd0});
    // seq 0 again now sits in the previous window
    plan.push_back('{ROW_PKT, 16'd0, 64'd0, 1'b1, srr_pkg::KIND_ACK, 1'b1, 1'b0,
                     6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'hFFFF, '1, 1'b1, srr_pkg::KIND_RANGE, 1'b1, 1'b0,
                     6'd0, 9'd0});
    // zero window and zero total clamp to 1: base 1 means the transfer is done
    plan.push_back('{ROW_CFG, 16'd0, 64'd0, 1'b0, srr_pkg::KIND_ACK, 1'b0, 1'b0,
                     6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd3, 64'hA5A5_5A5A_A5A5_5A5A, 1'b1, srr_pkg::KIND_DONE,
                     1'b1, 1'b1, 6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'hFFFF, '1, 1'b1, srr_pkg::KIND_DONE, 1'b1, 1'b1,
                     6'd0, 9'd0});
    // oversized settings clamp to a 32 wide window and 256 chunks
    plan.push_back('{ROW_CFG, 16'd0, 64'd0, 1'b0, srr_pkg::KIND_ACK, 1'b0, 1'b0,
                     6'd63, 9'd511});
    plan.push_back('{ROW_PKT, 16'd33, 64'd0, 1'b1, srr_pkg::KIND_RANGE, 1'b1, 1'b0,
                     6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd32, 64'h0123_4567_89AB_CDEF, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    // duplicate in window overwrites the slot but is delivered once
    plan.push_back('{ROW_PKT, 16'd32, 64'hFEDC_BA98_7654_3210, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    plan.push_back('{ROW_CFG, 16'd0, 64'd0, 1'b0, srr_pkg::KIND_ACK, 1'b0, 1'b0,
                     6'd4, 9'd256});
    plan.push_back('{ROW_PKT, 16'd4, 64'h4444_0000_0000_0004, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd3, 64'h3333_0000_0000_0003, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd2, 64'h2222_0000_0000_0002, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd1, 64'h1111_0000_0000_0001, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd0, 64'd0, 1'b0, srr_pkg::KIND_ACK, 1'b0, 1'b0,
                     6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd1, 64'd0, 1'b1, srr_pkg::KIND_ACK, 1'b1, 1'b0,
                     6'd0, 9'd0});
    // small total: an in-window sequence past the total is rejected
    plan.push_back('{ROW_CFG, 16'd0, 64'd0, 1'b0, srr_pkg::KIND_ACK, 1'b0, 1'b0,
                     6'd32, 9'd7});
    plan.push_back('{ROW_PKT, 16'd6, 64'h6666_0000_0000_0006, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd7, 64'd0, 1'b1, srr_pkg::KIND_RANGE, 1'b1, 1'b0,
                     6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd5, 64'h5555_0000_0000_0005, 1'b0, srr_pkg::KIND_ACK,
                     1'b0, 1'b0, 6'd0, 9'd0});
    plan.push_back('{ROW_PKT, 16'd0, 64'd0, 1'b1, srr_pkg::KIND_DONE, 1'b1, 1'b1,
                     6'd0, 9'd0});

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        drain();
        write_cfg(plan[i].win, plan[i].tot);
      end else begin
        offer_packet(plan[i].seq, plan[i].pl);
        predict_packet(plan[i].seq, plan[i].pl, produced);
        if (plan[i].typed) begin
          // swap the shadow's word for the typed one; both must agree on one word
          if (produced != 1) begin
            flag_mismatch($sformatf("directed seq %0d: shadow gives %0d words",
                                    plan[i].seq, produced));
          end else begin
            void'(expected_words.pop_back());
            expected_words.push_back('{plan[i].kind, plan[i].seq, DATA_W'(0),
                                       plan[i].last, plan[i].done_res});
          end
        end
      end
    end

    // Random phases: new settings, then a few runs that walk the window forward
    while (packets_sent < TOTAL_ITEMS) begin
      drain();
      rnd = $urandom_range(0, 9);
      case (rnd)
        0:       next_win = 6'd0;
        1:       next_win = WIN_CFG_W'($urandom_range(33, 63));
        2:       next_win = 6'd32;
        default: next_win = WIN_CFG_W'($urandom_range(1, 32));
      endcase
      rnd = $urandom_range(0, 19);
      case (rnd)
        0, 1, 2: next_tot = TOT_CFG_W'(win_base + $urandom_range(1, 12));
        3, 4:    next_tot = TOT_CFG_W'($urandom_range(257, 511));
        5:       next_tot = 9'd0;
        default: next_tot = 9'd256;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      write_cfg(next_win, next_tot);

      repeat ($urandom_range(2, 4)) begin
        w = eff_window();
        k = w;
        burst_seqs.delete();
        for (j = 0; j < k; j++) burst_seqs.push_back(win_base + j);
        if ($urandom_range(0, 3) == 0) begin
          // base last: the final packet releases the whole window at once
          tmp = burst_seqs.pop_front();
          burst_seqs.push_back(tmp);
        end else begin
          for (j = k - 1; j > 0; j--) begin
            rnd = $urandom_range(0, j);
            tmp = burst_seqs[j];
            burst_seqs[j] = burst_seqs[rnd];
            burst_seqs[rnd] = tmp;
          end
        end
        foreach (burst_seqs[n]) begin
          if (packets_sent >= TOTAL_ITEMS) break;
          if ($urandom_range(0, 3) == 0) begin
            case (noise_e'($urandom_range(0, 3)))
              NOISE_DUP:  nseq = win_base + $urandom_range(0, w - 1);
              NOISE_OLD:  nseq = int'(win_base) - int'($urandom_range(1, w));
              NOISE_WILD: nseq = $urandom_range(0, 65535);
              default:    nseq = win_base + w;
            endcase
            offer_packet(SEQ_W'(nseq), {$urandom, $urandom});
            predict_packet(pkt.seq_num, pkt.payload, produced);
          end
          offer_packet(SEQ_W'(burst_seqs[n]), {$urandom, $urandom});
          predict_packet(pkt.seq_num, pkt.payload, produced);
        end
      end
    end

    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/srr_pkg.sv
rtl/srr_if.sv
rtl/srr_ram.sv
rtl/srr_alu.sv
rtl/selective_repeat_receiver_core.sv
dv/selective_repeat_receiver_core_test.sv
